// ===== rtl/oilt_pkg.sv =====
// Shared constants, operation codes and status codes for the ordered index list table.
`timescale 1ns / 1ps
package oilt_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_BITS_DEF = 16;

  localparam int FUNC_W   = 3;
  localparam int KEY_W    = 16;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 7;
  localparam int VALUE_W  = 17;
  localparam int COUNT_W  = 7;

  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ADD    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_SWAP   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_FIND   = 3'd4;
  localparam logic [FUNC_W-1:0] FN_READ   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REORDERED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CORRUPT   = 2'd3;

  localparam logic signed [SLOT_W-1:0]  SLOT_NONE  = -7'sd1;
  localparam logic signed [VALUE_W-1:0] VALUE_NONE = -17'sd1;

endpackage

// ===== rtl/oilt_req_if.sv =====
// Request channel carrying one operation item.
`timescale 1ns / 1ps
interface oilt_req_if;
  import oilt_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [KEY_W-1:0]  key_a;
  logic [KEY_W-1:0]  key_b;
  logic [POS_W-1:0]  position;

  modport source (output valid, func, key_a, key_b, position, input ready);
  modport sink (input valid, func, key_a, key_b, position, output ready);
endinterface

// ===== rtl/oilt_rsp_if.sv =====
// Response channel carrying one result item.
`timescale 1ns / 1ps
interface oilt_rsp_if;
  import oilt_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic signed [SLOT_W-1:0]   logical_position;
  logic signed [SLOT_W-1:0]   physical_slot;
  logic signed [VALUE_W-1:0]  read_value;
  logic [COUNT_W-1:0]         count;

  modport source (output valid, status, logical_position, physical_slot, read_value, count,
                  input ready);
  modport sink (input valid, status, logical_position, physical_slot, read_value, count,
                output ready);
endinterface

// ===== rtl/ordered_index_list_table.sv =====
// Top level of the ordered index list table: slot ring, sequencer and ordered mirror.
`timescale 1ns / 1ps
// The block keeps an ordered list of keys in CAPACITY slots and answers one
// operation item on the req channel with exactly one result item on rsp.
// Operations are clear, add, remove, swap, find and read of the ordered mirror.
// The slots form a ring of cells that rotates once per pass; slot k reaches
// the sequencer at the tail of the ring when the pass counter equals k.
// Add, remove and find need one pass, a swap whose keys are both found needs
// two passes, and an add that has to compact the slots needs one pass fed
// from the mirror memory. Read and clear need no pass. The ring pass sets
// the pace: one item is worked on at a time, and req is ready again only
// once the sequencer is idle.
// After reset all slots and the mirror are empty and the count is zero.
// A finished result waits in the output register while req is ready again;
// if rsp stalls, the next result waits in the sequencer until rsp is free.
module ordered_index_list_table
  import oilt_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  oilt_req_if.sink  req,
  oilt_rsp_if.source rsp
);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_PASS    = 9'b000000010,
    S_END     = 9'b000000100,
    S_SWAP    = 9'b000001000,
    S_PREP    = 9'b000010000,
    S_COMPACT = 9'b000100000,
    S_READ    = 9'b001000000,
    S_RGET    = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  state_t                     state;
  logic [IDX_W-1:0]           k;
  logic [CNT_W-1:0]           occ;
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           hw_n;
  logic [FUNC_W-1:0]          op;
  logic [KEY_BITS-1:0]        ka;
  logic [KEY_BITS-1:0]        kb;
  logic [POS_W-1:0]           pos_r;
  logic                       fa;
  logic                       fb;
  logic [IDX_W-1:0]           sa;
  logic [IDX_W-1:0]           sb;
  logic [CNT_W-1:0]           pa;
  logic [STATUS_W-1:0]        res_status;
  logic signed [SLOT_W-1:0]   res_lpos;
  logic signed [SLOT_W-1:0]   res_pslot;
  logic signed [VALUE_W-1:0]  res_rval;
  logic [CAPACITY-1:0]        mvalid;

  logic                       cv [CAPACITY];
  logic [KEY_BITS-1:0]        ck [CAPACITY];
  logic                       ins_v;
  logic [KEY_BITS-1:0]        ins_k;
  logic                       shift;
  logic                       accept;
  logic                       clr;
  logic                       tv;
  logic [KEY_BITS-1:0]        tk;
  logic                       match_a;
  logic                       match_b;
  logic                       last;
  logic                       rebuild;
  logic                       m_we;
  logic [IDX_W-1:0]           m_waddr;
  logic [KEY_BITS-1:0]        m_wdata;
  logic [IDX_W-1:0]           m_raddr;
  logic [KEY_BITS-1:0]        m_rdata;
  logic                       pos_in_range;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign clr       = accept && (req.func == FN_CLEAR);
  assign shift     = (state == S_PASS) || (state == S_SWAP) || (state == S_COMPACT);
  assign tv        = cv[CAPACITY-1];
  assign tk        = ck[CAPACITY-1];
  assign match_a   = tv && (tk == ka);
  assign match_b   = tv && (tk == kb);
  assign last      = (k == IDX_W'(CAPACITY - 1));
  assign rebuild   = ((state == S_PASS) && ((op == FN_ADD) || (op == FN_REMOVE))) ||
                     (state == S_SWAP);
  assign pos_in_range = (int'(pos_r) < CAPACITY);

  // The ring: cell 0 takes what the sequencer inserts, the tail feeds the sequencer.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_ring
    if (i == 0) begin : g_head
      oilt_cell #(.KEY_BITS(KEY_BITS)) u_cell (
        .clk(clk), .rst(rst), .clr(clr), .shift(shift),
        .d_valid(ins_v), .d_key(ins_k), .q_valid(cv[i]), .q_key(ck[i])
      );
    end else begin : g_body
      oilt_cell #(.KEY_BITS(KEY_BITS)) u_cell (
        .clk(clk), .rst(rst), .clr(clr), .shift(shift),
        .d_valid(cv[i-1]), .d_key(ck[i-1]), .q_valid(cv[i]), .q_key(ck[i])
      );
    end
  end

  // What goes back into the ring for slot k in this cycle.
  always_comb begin
    ins_v = tv;
    ins_k = tk;
    case (state)
      S_PASS: begin
        if ((op == FN_ADD) && (k == IDX_W'(hw_n))) begin
          ins_v = 1'b1;
          ins_k = ka;
        end else if ((op == FN_REMOVE) && match_a && !fa) begin
          ins_v = 1'b0;
        end
      end
      S_SWAP: begin
        if (k == sa) begin
          ins_k = kb;
        end else if (k == sb) begin
          ins_k = ka;
        end
      end
      S_COMPACT: begin
        if (CNT_W'(k) < count) begin
          ins_v = 1'b1;
          ins_k = m_rdata;
        end else if (CNT_W'(k) == count) begin
          ins_v = 1'b1;
          ins_k = ka;
        end else begin
          ins_v = 1'b0;
          ins_k = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Mirror memory ports. A rebuild writes each occupied key in list order;
  // compaction only adds the new key at the old count.
  always_comb begin
    m_we    = 1'b0;
    m_waddr = IDX_W'(occ);
    m_wdata = ins_k;
    m_raddr = '0;
    if (rebuild && ins_v) begin
      m_we = 1'b1;
    end
    case (state)
      S_COMPACT: begin
        m_raddr = k + IDX_W'(1);
        if (CNT_W'(k) == count) begin
          m_we    = 1'b1;
          m_waddr = IDX_W'(count);
          m_wdata = ka;
        end
      end
      S_READ: begin
        m_raddr = IDX_W'(pos_r);
      end
      default: begin
      end
    endcase
  end

  oilt_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_mirror (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      hw_n      <= '0;
      mvalid    <= '0;
      rsp.valid <= 1'b0;
    end else begin
      // In S_DONE the output register is reloaded below instead.
      if (rsp.valid && rsp.ready && (state != S_DONE)) begin
        rsp.valid <= 1'b0;
      end
      if (m_we) begin
        mvalid[m_waddr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op         <= req.func;
            ka         <= KEY_BITS'(req.key_a);
            kb         <= KEY_BITS'(req.key_b);
            pos_r      <= req.position;
            k          <= '0;
            occ        <= '0;
            fa         <= 1'b0;
            fb         <= 1'b0;
            res_status <= ST_OK;
            res_lpos   <= '0;
            res_pslot  <= '0;
            res_rval   <= '0;
            case (req.func)
              FN_CLEAR: begin
                count  <= '0;
                hw_n   <= '0;
                mvalid <= '0;
                state  <= S_DONE;
              end
              FN_ADD: begin
                if (hw_n < CNT_W'(CAPACITY)) begin
                  state <= S_PASS;
                end else if (count == CNT_W'(CAPACITY)) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else begin
                  state <= S_PREP;
                end
              end
              FN_REMOVE, FN_SWAP, FN_FIND: begin
                state <= S_PASS;
              end
              FN_READ: begin
                state <= S_READ;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_PASS: begin
          k <= k + IDX_W'(1);
          if (ins_v) begin
            occ <= occ + CNT_W'(1);
          end
          if (match_a && !fa) begin
            fa <= 1'b1;
            sa <= k;
            pa <= occ;
          end
          if (match_b && !fb) begin
            fb <= 1'b1;
            sb <= k;
          end
          if (last) begin
            state <= S_END;
          end
        end
        S_END: begin
          state <= S_DONE;
          case (op)
            FN_ADD: begin
              count <= count + CNT_W'(1);
              hw_n  <= hw_n + CNT_W'(1);
            end
            FN_REMOVE: begin
              if (fa) begin
                count <= count - CNT_W'(1);
              end
            end
            FN_FIND: begin
              res_lpos  <= fa ? SLOT_W'(pa) : SLOT_NONE;
              res_pslot <= fa ? SLOT_W'(sa) : SLOT_NONE;
            end
            FN_SWAP: begin
              if (fa && fb) begin
                k     <= '0;
                occ   <= '0;
                state <= S_SWAP;
              end else begin
                res_status <= ST_CORRUPT;
              end
            end
            default: begin
            end
          endcase
        end
        S_SWAP: begin
          k <= k + IDX_W'(1);
          if (ins_v) begin
            occ <= occ + CNT_W'(1);
          end
          if (last) begin
            state <= S_DONE;
          end
        end
        S_PREP: begin
          k     <= '0;
          state <= S_COMPACT;
        end
        S_COMPACT: begin
          k <= k + IDX_W'(1);
          if (last) begin
            hw_n       <= count + CNT_W'(1);
            count      <= count + CNT_W'(1);
            res_status <= ST_REORDERED;
            state      <= S_DONE;
          end
        end
        S_READ: begin
          state <= S_RGET;
        end
        S_RGET: begin
          if (pos_in_range && mvalid[IDX_W'(pos_r)]) begin
            res_rval <= VALUE_W'(m_rdata);
          end else begin
            res_rval <= VALUE_NONE;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid            <= 1'b1;
            rsp.status           <= res_status;
            rsp.logical_position <= res_lpos;
            rsp.physical_slot    <= res_pslot;
            rsp.read_value       <= res_rval;
            rsp.count            <= COUNT_W'(count);
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// ===== rtl/oilt_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module oilt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/oilt_cell.sv =====
// One storage slot of the rotating slot ring.
`timescale 1ns / 1ps
module oilt_cell #(
  parameter int KEY_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                clr,
  input  logic                shift,
  input  logic                d_valid,
  input  logic [KEY_BITS-1:0] d_key,
  output logic                q_valid,
  output logic [KEY_BITS-1:0] q_key
);
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      q_valid <= 1'b0;
    end else if (shift) begin
      q_valid <= d_valid;
    end
    if (shift) begin
      q_key <= d_key;
    end
  end
endmodule
